>>> rtl/huffman_encode_bit_packer_assert.svh
// assertion macros used by the huffman bit packer port-level checker
// no dependencies; expects clk and rst_n in the including scope
`ifndef HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HEBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HEBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hebp_pkg.sv
// types and constants of the huffman encoder bit packer
// no dependencies
package hebp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CMD_W       = 2;
  localparam int SYM_W       = 8;
  localparam int CLEN_W      = 6;
  localparam int CODE_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int PAD_W       = 3;
  localparam int IN_DATA_W   = 48;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic load_we;
    logic rd_en;
    logic capture;
    logic step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic can_step;
    logic step_ends;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/hebp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module hebp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hebp_ctrl.sv
// controller state machine of the huffman encoder bit packer
// depends on hebp_pkg
module hebp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [hebp_pkg::CMD_W-1:0]   in_command,
  input  hebp_pkg::dp_status_t         sts,
  output logic                         in_ready,
  output hebp_pkg::ctrl_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_EMIT   = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_command)
            hebp_pkg::CMD_LOAD: begin
              cmd.load_we = 1'b1;
            end
            hebp_pkg::CMD_ENCODE: begin
              cmd.rd_en = 1'b1;
              state_nxt = S_LOOKUP;
            end
            hebp_pkg::CMD_FLUSH: begin
              state_nxt = S_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOKUP: begin
        cmd.capture = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.rem_zero) begin
          state_nxt = S_IDLE;
        end else if (sts.can_step) begin
          cmd.step = 1'b1;
          if (sts.step_ends) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/hebp_dp.sv
// datapath: code table, bit accumulator, code shifter and output register
// depends on hebp_pkg and hebp_ram
module hebp_dp #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hebp_pkg::ctrl_cmd_t           cmd,
  output hebp_pkg::dp_status_t          sts,
  input  logic [hebp_pkg::SYM_W-1:0]    in_symbol,
  input  logic [hebp_pkg::CLEN_W-1:0]   in_code_length,
  input  logic [hebp_pkg::CODE_W-1:0]   in_code_bits,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [hebp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic [hebp_pkg::PAD_W-1:0]    out_pad
);

  localparam int CAP   = (MAX_CODE_LEN < hebp_pkg::CODE_W) ? MAX_CODE_LEN : hebp_pkg::CODE_W;
  localparam int LEN_W = $clog2(CAP + 1);
  localparam int ENT_W = LEN_W + CAP;
  localparam int SH_W  = CAP + 8;
  localparam int CMP_W = (LEN_W > 4) ? LEN_W : 4;

  // table write path
  logic [hebp_pkg::CLEN_W-1:0] len_clamp;
  logic [hebp_pkg::CODE_W-1:0] code_masked;
  logic [ENT_W-1:0]            wr_data;
  logic [ENT_W-1:0]            rd_data;

  assign len_clamp   = (in_code_length > hebp_pkg::CLEN_W'(CAP)) ?
                       hebp_pkg::CLEN_W'(CAP) : in_code_length;
  assign code_masked = in_code_bits & ~(32'hFFFF_FFFF << len_clamp);
  assign wr_data     = {len_clamp[LEN_W-1:0], code_masked[CAP-1:0]};

  hebp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (hebp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (in_symbol),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (in_symbol),
    .rdata (rd_data)
  );

  logic [hebp_pkg::TABLE_DEPTH-1:0] vld_r;
  logic                             vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (cmd.load_we) begin
        vld_r[in_symbol] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_q_r <= vld_r[in_symbol];
      end
    end
  end

  // lookup alignment
  logic [LEN_W-1:0] rd_len;
  logic [CAP-1:0]   rd_code;
  logic [SH_W-1:0]  sh_load;

  assign rd_len  = vld_q_r ? rd_data[ENT_W-1 -: LEN_W] : '0;
  assign rd_code = vld_q_r ? rd_data[CAP-1:0] : '0;
  assign sh_load = {rd_code, 8'h00} << (LEN_W'(CAP) - rd_len);

  // packing step
  logic [SH_W-1:0]              sh_r;
  logic [LEN_W-1:0]             rem_r;
  logic [hebp_pkg::BYTE_W-1:0]  pend_r;
  logic [2:0]                   pcnt_r;

  logic [3:0]                   need;
  logic [3:0]                   rem4;
  logic [3:0]                   take;
  logic                         full;
  logic [LEN_W-1:0]             rem_after;
  logic [7:0]                   top8;
  logic [7:0]                   emit_byte;
  logic [7:0]                   merge_byte;
  logic [7:0]                   flush_byte;
  logic                         emit_last;
  logic                         flush_go;

  assign need       = 4'd8 - {1'b0, pcnt_r};
  assign rem4       = 4'(rem_r);
  assign full       = CMP_W'(rem_r) >= CMP_W'(need);
  assign take       = full ? need : rem4;
  assign rem_after  = rem_r - LEN_W'(take);
  assign top8       = sh_r[SH_W-1 -: 8];
  assign emit_byte  = (pend_r << need) | (top8 >> {1'b0, pcnt_r});
  assign merge_byte = (pend_r << rem4) | (top8 >> (4'd8 - rem4));
  assign flush_byte = pend_r << need;
  assign emit_last  = CMP_W'(rem_after) < CMP_W'(8);
  assign flush_go   = cmd.flush && (pcnt_r != 3'd0);

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [2:0] out_pad_r;

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.can_step  = (rem_r != '0) && (!full || sts.out_free);
  assign sts.step_ends = (rem_after == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rem_r <= rd_len;
      end else if (cmd.step) begin
        rem_r <= rem_after;
      end
      if (cmd.step) begin
        if (full) begin
          pend_r <= '0;
          pcnt_r <= '0;
        end else begin
          pend_r <= merge_byte;
          pcnt_r <= pcnt_r + 3'(rem_r);
        end
      end else if (flush_go) begin
        pend_r <= '0;
        pcnt_r <= '0;
      end
      if ((cmd.step && full) || flush_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sh_r <= sh_load;
    end else if (cmd.step) begin
      sh_r <= sh_r << take;
    end
    if (cmd.step && full) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_pad_r  <= 3'd0;
    end else if (flush_go) begin
      out_byte_r <= flush_byte;
      out_last_r <= 1'b1;
      out_pad_r  <= need[2:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_pad   = out_pad_r;

endmodule

>>> rtl/huffman_encode_bit_packer.sv
// top level of the huffman encoder bit packer: controller plus datapath
// depends on hebp_pkg, hebp_ctrl, hebp_dp, hebp_ram
//
//   channel | dir | handshake        | payload
//   in_     | in  | tvalid / tready  | tdata: command, symbol, code_length, code_bits
//   out_    | out | tvalid / tready  | tdata: out_byte; tlast: last; tuser: pad_bits
//
// load writes the table entry from idle; flush waits until the output register is free;
// encode reads the table, captures the entry, then takes one packing step per output byte
// (0 to 4) and one more when leftover code bits go into the partial byte
// after reset every table entry is marked invalid and encodes as zero bits, no clearing pass
// a stalled output holds a byte-emitting packing step until its byte register is taken
module huffman_encode_bit_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // command[1:0], symbol[9:2], code_length[15:10], code_bits[47:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // pad_bits[2:0]
);

  hebp_pkg::ctrl_cmd_t  cmd;
  hebp_pkg::dp_status_t sts;

  hebp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tdata[1:0]),
    .sts        (sts),
    .in_ready   (in_tready),
    .cmd        (cmd)
  );

  hebp_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_symbol      (in_tdata[9:2]),
    .in_code_length (in_tdata[15:10]),
    .in_code_bits   (in_tdata[47:16]),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_byte       (out_tdata),
    .out_last       (out_tlast),
    .out_pad        (out_tuser)
  );

endmodule

>>> rtl/hebp_checker.sv
// port-level checker for the huffman encoder bit packer, bound to the top level
// depends on hebp_pkg and huffman_encode_bit_packer_assert.svh
`include "huffman_encode_bit_packer_assert.svh"

module hebp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  // padded byte always closes its transaction
  `HEBP_ASSERT_NOW(a_pad_is_last, out_tvalid && (out_tuser != 3'd0), out_tlast, "pad without last")

  // pad bits are zero
  `HEBP_ASSERT_NOW(a_pad_zero, out_tvalid && (out_tuser != 3'd0), (out_tdata & ~(8'hFF << out_tuser)) == 8'h00, "nonzero pad bits")

  // a table load never produces output
  `HEBP_ASSERT_NEXT(a_load_silent, in_tvalid && in_tready && (in_tdata[1:0] == hebp_pkg::CMD_LOAD) && !out_tvalid, !out_tvalid, "output after load")

  // stalled output holds
  `HEBP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "output changed while stalled")

endmodule

bind huffman_encode_bit_packer hebp_checker u_hebp_checker (.*);

>>> tb/hebp_checker.sv
// transaction checker for the huffman encoder bit packer: tracks the code table and
// bit accumulator from accepted input transactions and compares every output byte
// depends on hebp_pkg
module hebp_tb_checker #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hebp_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hebp_pkg::BYTE_W-1:0]    out_tdata,
  input  logic                           out_tlast,
  input  logic [hebp_pkg::PAD_W-1:0]     out_tuser,
  output int                             errors,
  output int                             bytes_left,
  output int                             items_seen,
  output int                             bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_CAP = (MAX_CODE_LEN < hebp_pkg::CODE_W) ? MAX_CODE_LEN : hebp_pkg::CODE_W;

  typedef struct packed {
    logic [hebp_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [hebp_pkg::PAD_W-1:0]  pad;
  } coded_byte_t;

  logic [hebp_pkg::CLEN_W-1:0] code_len [hebp_pkg::TABLE_DEPTH];
  logic [hebp_pkg::CODE_W-1:0] code_val [hebp_pkg::TABLE_DEPTH];
  logic [hebp_pkg::BYTE_W-1:0] acc_bits;
  int                          acc_count;
  coded_byte_t                 byte_queue [$];
  coded_byte_t                 want;
  int                          err_count  = 0;
  int                          item_count = 0;
  int                          byte_count = 0;

  task automatic apply_command(input logic [hebp_pkg::CMD_W-1:0] cmd,
                               input logic [hebp_pkg::SYM_W-1:0] sym,
                               input logic [hebp_pkg::CLEN_W-1:0] len,
                               input logic [hebp_pkg::CODE_W-1:0] bits);
    coded_byte_t made [4];
    int          n;
    int          k;
    logic [63:0] mask;
    n = 0;
    case (cmd)
      hebp_pkg::CMD_LOAD: begin
        if (len > LEN_CAP) len = hebp_pkg::CLEN_W'(LEN_CAP);
        mask = (64'd1 << len) - 64'd1;
        code_len[sym] = len;
        code_val[sym] = bits & mask[hebp_pkg::CODE_W-1:0];
      end
      hebp_pkg::CMD_ENCODE: begin
        for (k = int'(code_len[sym]); k > 0; k--) begin
          acc_bits = {acc_bits[hebp_pkg::BYTE_W-2:0], code_val[sym][k-1]};
          acc_count++;
          if (acc_count == hebp_pkg::BYTE_W) begin
            made[n].data = acc_bits;
            made[n].last = 1'b0;
            made[n].pad  = '0;
            n++;
            acc_bits  = '0;
            acc_count = 0;
          end
        end
        if (n > 0) made[n-1].last = 1'b1;
      end
      hebp_pkg::CMD_FLUSH: begin
        if (acc_count != 0) begin
          made[0].data = acc_bits << (hebp_pkg::BYTE_W - acc_count);
          made[0].last = 1'b1;
          made[0].pad  = hebp_pkg::PAD_W'(hebp_pkg::BYTE_W - acc_count);
          n = 1;
          acc_bits  = '0;
          acc_count = 0;
        end
      end
      default: ;
    endcase
    for (k = 0; k < n; k++) byte_queue = {byte_queue, made[k]};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hebp_pkg::TABLE_DEPTH; i++) begin
        code_len[i] = '0;
        code_val[i] = '0;
      end
      acc_bits  = '0;
      acc_count = 0;
      byte_queue.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        item_count++;
        apply_command(in_tdata[1:0], in_tdata[9:2], in_tdata[15:10], in_tdata[47:16]);
      end
      if (out_tvalid && out_tready) begin
        byte_count++;
        if (byte_queue.size() == 0) begin
          err_count++;
          $display("%0t: unexpected output byte: expected none, actual byte %h last %b pad %0d",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          want = byte_queue.pop_front();
          if (out_tdata !== want.data) begin
            err_count++;
            $display("%0t: byte mismatch: expected %h, actual %h", $time, want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            err_count++;
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, out_tlast);
          end
          if (out_tuser !== want.pad) begin
            err_count++;
            $display("%0t: pad mismatch: expected %0d, actual %0d", $time, want.pad, out_tuser);
          end
        end
      end
    end
    errors     <= err_count;
    bytes_left <= byte_queue.size();
    items_seen <= item_count;
    bytes_seen <= byte_count;
  end

endmodule

>>> tb/tb_top.sv
// top of the huffman encoder bit packer testbench: clock, reset, stimulus, output
// backpressure and verdict; depends on hebp_pkg, hebp_tb_checker and the packer rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         MAX_LEN        = 32;
  localparam logic [hebp_pkg::CMD_W-1:0] CMD_UNUSED     = 2'd3;
  localparam int                         RANDOM_ITEMS   = 440;
  localparam int                         PRESSURE_AT    = 200;
  localparam int                         PRESSURE_ITEMS = 30;
  localparam int                         HOLD_CYCLES    = 300;
  localparam int                         DRAIN_CYCLES   = 20;
  localparam int                         WATCHDOG_LIMIT = 2000;
  localparam int                         POOL_SIZE      = 16;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [hebp_pkg::IN_DATA_W-1:0] in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [hebp_pkg::BYTE_W-1:0]    out_tdata;
  logic                           out_tlast;
  logic [hebp_pkg::PAD_W-1:0]     out_tuser;

  logic quiet     = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left   = 0;
  int   stall_left  = 0;
  int   rx_gap;
  int   idle_cycles = 0;
  int   errors;
  int   bytes_left;
  int   items_seen;
  int   bytes_seen;

  logic [hebp_pkg::SYM_W-1:0] sym_pool [POOL_SIZE];

  huffman_encode_bit_packer #(.MAX_CODE_LEN(MAX_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  hebp_tb_checker #(.MAX_CODE_LEN(MAX_LEN)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .bytes_left (bytes_left),
    .items_seen (items_seen),
    .bytes_seen (bytes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_item(input logic [hebp_pkg::CMD_W-1:0] cmd,
                           input logic [hebp_pkg::SYM_W-1:0] sym,
                           input logic [hebp_pkg::CLEN_W-1:0] len,
                           input logic [hebp_pkg::CODE_W-1:0] bits);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bits, len, sym, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // output backpressure: random stall per transaction, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_gap = quiet ? 0 : $urandom_range(0, 10);
      stall_left <= (rx_gap == 0) ? 0 : rx_gap - 1;
      out_tready <= (rx_gap == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles without a transaction, %0d bytes due",
               $time, idle_cycles, bytes_left);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                          n_items;
    int                          r;
    int                          pick;
    bit                          pressure_done;
    logic [hebp_pkg::CLEN_W-1:0] len;
    logic [hebp_pkg::SYM_W-1:0]  sym;
    n_items       = 0;
    pressure_done = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      sym_pool[i] = hebp_pkg::SYM_W'($urandom_range(0, 255));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // unloaded symbol, empty flush and a full 32-bit code
    push_item(hebp_pkg::CMD_ENCODE, 8'd0, hebp_pkg::CLEN_W'($urandom()), $urandom());
    push_item(hebp_pkg::CMD_FLUSH, 8'd0, '0, '0);
    push_item(hebp_pkg::CMD_LOAD, 8'd255, 6'd32, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_ENCODE, 8'd255, hebp_pkg::CLEN_W'($urandom()), $urandom());
    // bits above length, overlong length, zero length, all-zero code
    push_item(hebp_pkg::CMD_LOAD, 8'd0, 6'd1, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_LOAD, 8'd1, 6'd63, 32'hA5A5_5A5A);
    push_item(hebp_pkg::CMD_LOAD, 8'd2, 6'd0, 32'hDEAD_BEEF);
    push_item(hebp_pkg::CMD_LOAD, 8'd3, 6'd7, 32'h0000_0000);
    push_item(hebp_pkg::CMD_ENCODE, 8'd0, '0, '0);
    push_item(hebp_pkg::CMD_ENCODE, 8'd1, 6'h3F, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_ENCODE, 8'd2, '0, '0);
    push_item(hebp_pkg::CMD_FLUSH, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_ENCODE, 8'd3, '0, '0);
    push_item(hebp_pkg::CMD_ENCODE, 8'd0, '0, '0);
    push_item(hebp_pkg::CMD_FLUSH, 8'd0, '0, '0);
    push_item(hebp_pkg::CMD_ENCODE, 8'd3, '0, '0);
    push_item(hebp_pkg::CMD_FLUSH, 8'd0, '0, '0);
    push_item(CMD_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_LOAD, 8'd128, 6'd31, 32'hFFFF_FFFF);
    push_item(hebp_pkg::CMD_ENCODE, 8'd128, '0, '0);
    push_item(hebp_pkg::CMD_ENCODE, 8'd128, '0, '0);
    push_item(hebp_pkg::CMD_FLUSH, 8'd0, '0, '0);

    for (int i = 0; i < POOL_SIZE; i++) begin
      push_item(hebp_pkg::CMD_LOAD, sym_pool[i], hebp_pkg::CLEN_W'($urandom_range(1, 12)),
                $urandom());
      n_items++;
    end

    while (n_items < RANDOM_ITEMS) begin
      if (!pressure_done && n_items >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        quiet    <= 1'b1;
        push_item(hebp_pkg::CMD_LOAD, sym_pool[0], 6'd32, $urandom());
        hold_req <= ~hold_req;
        repeat (PRESSURE_ITEMS) push_item(hebp_pkg::CMD_ENCODE, sym_pool[0],
                                          hebp_pkg::CLEN_W'($urandom()), $urandom());
        n_items += PRESSURE_ITEMS + 1;
      end else begin
        quiet <= (n_items % 100) >= 75;
        r   = $urandom_range(0, 99);
        sym = ($urandom_range(0, 99) < 85) ? sym_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : hebp_pkg::SYM_W'($urandom());
        if (r < 20) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      len = hebp_pkg::CLEN_W'($urandom_range(1, 12));
          else if (pick < 85) len = hebp_pkg::CLEN_W'($urandom_range(13, 32));
          else if (pick < 93) len = '0;
          else                len = hebp_pkg::CLEN_W'($urandom_range(33, 63));
          push_item(hebp_pkg::CMD_LOAD, sym, len, $urandom());
          n_items++;
        end else if (r < 90) begin
          push_item(hebp_pkg::CMD_ENCODE, sym, hebp_pkg::CLEN_W'($urandom()), $urandom());
          n_items++;
        end else if (r < 98) begin
          push_item(hebp_pkg::CMD_FLUSH, sym, hebp_pkg::CLEN_W'($urandom()), $urandom());
          n_items++;
        end else begin
          push_item(CMD_UNUSED, sym, hebp_pkg::CLEN_W'($urandom()), $urandom());
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transactions (loads, encodes, flushes, unused command)",
             items_seen);
    $display("and %0d output bytes under random stalls and one %0d-cycle output hold",
             bytes_seen, HOLD_CYCLES);
    if (errors == 0 && bytes_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
